// ----- src/scgb_pkg.sv -----
// Shared types and constants for the scatter-gather block cursor.
package scgb_pkg;

	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;
	typedef logic [1:0] reg_idx_t;

	localparam op_t OP_LOAD    = 2'd0;
	localparam op_t OP_ADVANCE = 2'd1;
	localparam op_t OP_CLEAR   = 2'd2;

	localparam status_t STATUS_OK      = 2'd0;
	localparam status_t STATUS_OVERRUN = 2'd1;
	localparam status_t STATUS_BEYOND  = 2'd2;

	localparam reg_idx_t REG_START_LBA    = 2'd0;
	localparam reg_idx_t REG_TOTAL_BLOCKS = 2'd1;
	localparam reg_idx_t REG_ENTRY_COUNT  = 2'd2;

	localparam int LBA_W   = 64;
	localparam int ADDR_W  = 64;
	localparam int LEN_W   = 32;
	localparam int COUNT_W = 21;
	localparam int POS_W   = 16;
	localparam int ENT_W   = 5;
	localparam int IDX_W   = 4;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam int S_DATA_W = 120;
	localparam int M_DATA_W = 176;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 64;

endpackage

// ----- src/scatter_gather_block_cursor_unit.sv -----
// Top level: block cursor over a scatter-gather descriptor table.
//
// Input stream (s_*): one transfer per command. s_tuser carries the opcode
// (load descriptor, advance, clear); s_tdata carries the slot, base, byte
// length and advance count. Output stream (m_*): one transfer per command
// with the cursor state after the command.
// Config: APB port, 64-bit data; start_lba at 0x00, total_blocks at 0x08,
// entry_count at 0x10. Write registers only while the block is idle.
// Load, clear, the unused opcode and advances with an empty table go from idle
// through the execute, fetch and result states; a table advance walks the
// descriptors between execute and fetch, with a registered descriptor memory
// read state and an evaluate state for each descriptor it visits.
// The next command is accepted once the previous result has been moved to
// the output register.
// Reset clears the cursor, registers and output valid. Descriptor memory is
// not cleared and must be loaded before the cursor points into it.
// A stalled m_tready holds the result; the block may accept and process one
// more command, then waits with its result until the output register frees.
module scatter_gather_block_cursor_unit #(
	parameter int MAX_ENTRIES     = 16,
	parameter int BLOCK_SIZE_LOG2 = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [scgb_pkg::PADDR_W-1:0]    paddr,
	input  logic [scgb_pkg::PDATA_W-1:0]    pwdata,
	output logic [scgb_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	// command stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// entry_index[3:0], entry_base[67:4], entry_length_bytes[99:68],
	// advance_count[115:100], zero pad[119:116]
	input  logic [scgb_pkg::S_DATA_W-1:0]   s_tdata,
	// op[1:0]
	input  logic [1:0]                      s_tuser,
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// current_lba[63:0], buffer_address[127:64], blocks_left_in_entry[148:128],
	// block_position[164:149], entry_position[169:165], status[171:170],
	// zero pad[175:172]
	output logic [scgb_pkg::M_DATA_W-1:0]   m_tdata
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int MaxEntW = $clog2(MAX_ENTRIES + 1) + 1;
	localparam logic [MaxEntW-1:0] MaxEnt = MaxEntW'(MAX_ENTRIES);
	localparam int ExtW = (MaxEntW > scgb_pkg::ENT_W) ? MaxEntW : scgb_pkg::ENT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK_RD,
		ST_WALK_EV,
		ST_FETCH,
		ST_RESULT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [scgb_pkg::LBA_W-1:0]   start_lba_q;
	logic [scgb_pkg::POS_W-1:0]   total_blocks_q;
	logic [scgb_pkg::ENT_W-1:0]   entry_count_q;

	// captured command
	scgb_pkg::op_t                op_q;
	logic [scgb_pkg::IDX_W-1:0]   idx_q;
	logic [scgb_pkg::ADDR_W-1:0]  base_q;
	logic [scgb_pkg::LEN_W-1:0]   len_q;

	// cursor
	logic [scgb_pkg::POS_W-1:0]   cursor_blocks_q;
	logic [scgb_pkg::ENT_W-1:0]   cursor_entry_q;
	logic [scgb_pkg::COUNT_W-1:0] cursor_offset_q;
	logic [scgb_pkg::POS_W-1:0]   left_q;
	logic                         overrun_q;

	logic                         m_tvalid_q;
	logic [scgb_pkg::M_DATA_W-1:0] m_tdata_q;

	// descriptor memory
	logic [scgb_pkg::ADDR_W-1:0]  base_mem  [MAX_ENTRIES];
	logic [scgb_pkg::COUNT_W-1:0] count_mem [MAX_ENTRIES];
	logic [scgb_pkg::ADDR_W-1:0]  rd_base_q;
	logic [scgb_pkg::COUNT_W-1:0] rd_count_q;

	logic                         cfg_wr;
	logic                         s_xfer;
	logic [scgb_pkg::ENT_W-1:0]   used_entries;
	logic                         entry_valid;
	logic [AW+scgb_pkg::IDX_W-1:0] wr_ext;
	logic [AW-1:0]                wr_addr;
	logic [AW+scgb_pkg::ENT_W-1:0] rd_ext;
	logic [AW-1:0]                rd_addr;
	logic                         wr_en;
	logic [scgb_pkg::LEN_W-1:0]   len_blocks;
	logic [scgb_pkg::COUNT_W-1:0] len_count;
	logic [scgb_pkg::POS_W:0]     pos_sum;
	logic [scgb_pkg::POS_W-1:0]   pos_sat;
	logic [scgb_pkg::COUNT_W:0]   walk_sum;
	logic [scgb_pkg::COUNT_W-1:0] give;
	logic [scgb_pkg::COUNT_W-1:0] left_diff;
	logic [scgb_pkg::POS_W-1:0]   left_next;
	logic [scgb_pkg::ADDR_W-1:0]  res_addr;
	logic [scgb_pkg::COUNT_W-1:0] res_left;
	scgb_pkg::status_t            res_status;
	logic [scgb_pkg::LBA_W-1:0]   res_lba;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid & s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		unique case (paddr[4:3])
			scgb_pkg::REG_START_LBA:    prdata = start_lba_q;
			scgb_pkg::REG_TOTAL_BLOCKS: prdata = {48'd0, total_blocks_q};
			scgb_pkg::REG_ENTRY_COUNT:  prdata = {59'd0, entry_count_q};
			default:                    prdata = '0;
		endcase
	end

	// entries in use: min(entry_count, MAX_ENTRIES)
	always_comb begin
		logic [ExtW-1:0] cnt_ext;
		logic [ExtW-1:0] max_ext;
		cnt_ext = ExtW'(entry_count_q);
		max_ext = ExtW'(MaxEnt);
		if (cnt_ext < max_ext) begin
			used_entries = entry_count_q;
		end else begin
			used_entries = scgb_pkg::ENT_W'(MAX_ENTRIES);
		end
	end

	assign entry_valid = (cursor_entry_q < used_entries);

	assign wr_ext  = {{AW{1'b0}}, idx_q};
	assign wr_addr = wr_ext[AW-1:0];
	assign rd_ext  = {{AW{1'b0}}, cursor_entry_q};
	assign rd_addr = rd_ext[AW-1:0];
	assign wr_en   = (state_q == ST_EXEC) && (op_q == scgb_pkg::OP_LOAD) &&
		(MaxEntW'(idx_q) < MaxEnt);

	// byte length to whole blocks, saturated
	assign len_blocks = len_q >> BLOCK_SIZE_LOG2;
	assign len_count  = (len_blocks > scgb_pkg::LEN_W'(scgb_pkg::COUNT_MAX)) ?
		scgb_pkg::COUNT_MAX : len_blocks[scgb_pkg::COUNT_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			base_mem[wr_addr]  <= base_q;
			count_mem[wr_addr] <= len_count;
		end
		rd_base_q  <= base_mem[rd_addr];
		rd_count_q <= count_mem[rd_addr];
	end

	// walk step against the descriptor just read
	always_comb begin
		pos_sum   = {1'b0, cursor_blocks_q} + (scgb_pkg::POS_W+1)'(s_tdata[115:100]);
		pos_sat   = pos_sum[scgb_pkg::POS_W] ? '1 : pos_sum[scgb_pkg::POS_W-1:0];
		walk_sum  = {1'b0, cursor_offset_q} + (scgb_pkg::COUNT_W+1)'(left_q);
		give      = (rd_count_q > cursor_offset_q) ? rd_count_q - cursor_offset_q : '0;
		left_diff = scgb_pkg::COUNT_W'(left_q) - give;
		left_next = (scgb_pkg::COUNT_W'(left_q) > give) ?
			left_diff[scgb_pkg::POS_W-1:0] : '0;
	end

	// result fields
	always_comb begin
		res_lba = start_lba_q + scgb_pkg::LBA_W'(cursor_blocks_q);
		if (entry_valid) begin
			res_addr = rd_base_q +
				(scgb_pkg::ADDR_W'(cursor_offset_q) << BLOCK_SIZE_LOG2);
			res_left = (rd_count_q > cursor_offset_q) ? rd_count_q - cursor_offset_q : '0;
		end else begin
			res_addr = '0;
			res_left = '0;
		end
		if (overrun_q) begin
			res_status = scgb_pkg::STATUS_OVERRUN;
		end else if (cursor_blocks_q > total_blocks_q) begin
			res_status = scgb_pkg::STATUS_BEYOND;
		end else begin
			res_status = scgb_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			start_lba_q     <= '0;
			total_blocks_q  <= '0;
			entry_count_q   <= '0;
			cursor_blocks_q <= '0;
			cursor_entry_q  <= '0;
			cursor_offset_q <= '0;
			left_q          <= '0;
			overrun_q       <= 1'b0;
			m_tvalid_q      <= 1'b0;
			op_q            <= scgb_pkg::OP_LOAD;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[4:3])
					scgb_pkg::REG_START_LBA:    start_lba_q    <= pwdata;
					scgb_pkg::REG_TOTAL_BLOCKS: total_blocks_q <= pwdata[15:0];
					scgb_pkg::REG_ENTRY_COUNT:  entry_count_q  <= pwdata[4:0];
					default: ;
				endcase
			end

			// in ST_RESULT the output register is handled by the state machine
			if (m_tvalid_q && m_tready && (state_q != ST_RESULT)) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						op_q      <= s_tuser;
						idx_q     <= s_tdata[3:0];
						base_q    <= s_tdata[67:4];
						len_q     <= s_tdata[99:68];
						left_q    <= s_tdata[115:100];
						overrun_q <= 1'b0;
						// saturating position update happens on capture
						if (s_tuser == scgb_pkg::OP_ADVANCE) begin
							cursor_blocks_q <= pos_sat;
						end
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (op_q)
						scgb_pkg::OP_ADVANCE: begin
							state_q <= (entry_count_q != '0) ? ST_WALK_RD : ST_FETCH;
						end
						scgb_pkg::OP_CLEAR: begin
							cursor_blocks_q <= '0;
							cursor_entry_q  <= '0;
							cursor_offset_q <= '0;
							state_q         <= ST_FETCH;
						end
						default: begin
							state_q <= ST_FETCH;
						end
					endcase
				end
				ST_WALK_RD: begin
					if (left_q == '0) begin
						state_q <= ST_FETCH;
					end else if (!entry_valid) begin
						overrun_q       <= 1'b1;
						cursor_entry_q  <= used_entries;
						cursor_offset_q <= '0;
						state_q         <= ST_FETCH;
					end else begin
						state_q <= ST_WALK_EV;
					end
				end
				ST_WALK_EV: begin
					if (walk_sum < {1'b0, rd_count_q}) begin
						cursor_offset_q <= walk_sum[scgb_pkg::COUNT_W-1:0];
						left_q          <= '0;
						state_q         <= ST_FETCH;
					end else begin
						// entry used up (or shrunk below offset): move on
						left_q          <= left_next;
						cursor_offset_q <= '0;
						cursor_entry_q  <= cursor_entry_q + 1'b1;
						state_q         <= ST_WALK_RD;
					end
				end
				ST_FETCH: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {4'd0, res_status, cursor_entry_q, cursor_blocks_q,
							res_left, res_addr, res_lba};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sim/tb.sv -----
// Testbench for the scatter-gather block cursor: directed and random commands, scoreboard check.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import scgb_pkg::*;

	localparam int MAX_ENTRIES = 16;
	localparam int BLOCK_LOG2  = 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam op_t OP_UNUSED  = 2'd3;

	// m_tdata[171:0], first member in the top bits
	typedef struct packed {
		status_t             status;
		logic [ENT_W-1:0]    entry_pos;
		logic [POS_W-1:0]    block_pos;
		logic [COUNT_W-1:0]  blocks_left;
		logic [ADDR_W-1:0]   buffer_addr;
		logic [LBA_W-1:0]    lba;
	} cursor_result_t;

	class cursor_tracker;
		logic [LBA_W-1:0]   start_lba;
		logic [POS_W-1:0]   total_blocks;
		logic [ENT_W-1:0]   entry_count;
		logic [POS_W-1:0]   pos_blocks;
		logic [ENT_W-1:0]   pos_entry;
		logic [COUNT_W-1:0] pos_offset;
		logic [ADDR_W-1:0]  slot_base [MAX_ENTRIES];
		logic [COUNT_W-1:0] slot_blocks [MAX_ENTRIES];
		cursor_result_t     expected_cursors [$];
		int                 mismatch_count;

		function new();
			start_lba = '0;
			total_blocks = '0;
			entry_count = '0;
			pos_blocks = '0;
			pos_entry = '0;
			pos_offset = '0;
			mismatch_count = 0;
		endfunction

		function void set_register(reg_idx_t idx, logic [PDATA_W-1:0] value);
			case (idx)
				REG_START_LBA: start_lba = value;
				REG_TOTAL_BLOCKS: total_blocks = value[POS_W-1:0];
				REG_ENTRY_COUNT: entry_count = value[ENT_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned table_size();
			return (entry_count < MAX_ENTRIES) ? entry_count : MAX_ENTRIES;
		endfunction

		// walk forward across descriptors; returns 1 when the walk runs off the table
		function bit walk_table(int unsigned left);
			int unsigned n;
			int unsigned blocks;
			int unsigned give;
			n = table_size();
			while (left > 0) begin
				if (pos_entry >= n) begin
					pos_entry = ENT_W'(n);
					pos_offset = '0;
					return 1'b1;
				end
				blocks = slot_blocks[pos_entry];
				if (pos_offset + left < blocks) begin
					pos_offset = COUNT_W'(pos_offset + left);
					return 1'b0;
				end
				// shrunk entries give nothing
				give = (blocks > pos_offset) ? blocks - pos_offset : 0;
				left = (left > give) ? left - give : 0;
				pos_offset = '0;
				pos_entry = pos_entry + 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_command(op_t op, logic [S_DATA_W-1:0] data);
			logic [IDX_W-1:0] idx;
			logic [LEN_W-1:0] len;
			int unsigned      sum;
			int unsigned      blocks;
			bit               overrun;
			cursor_result_t   r;
			idx = data[3:0];
			len = data[99:68];
			overrun = 1'b0;
			case (op)
				OP_LOAD: begin
					if (idx < MAX_ENTRIES) begin
						blocks = len >> BLOCK_LOG2;
						slot_base[idx] = data[67:4];
						slot_blocks[idx] = (blocks > COUNT_MAX) ? COUNT_MAX : COUNT_W'(blocks);
					end
				end
				OP_ADVANCE: begin
					sum = pos_blocks + data[115:100];
					pos_blocks = (sum > 16'hFFFF) ? 16'hFFFF : POS_W'(sum);
					if (entry_count != 0)
						overrun = walk_table(data[115:100]);
				end
				OP_CLEAR: begin
					pos_blocks = '0;
					pos_entry = '0;
					pos_offset = '0;
				end
				default: ;
			endcase
			r = '0;
			r.lba = start_lba + pos_blocks;
			if (pos_entry < table_size()) begin
				r.buffer_addr = slot_base[pos_entry] + (ADDR_W'(pos_offset) << BLOCK_LOG2);
				r.blocks_left = (slot_blocks[pos_entry] > pos_offset) ?
					slot_blocks[pos_entry] - pos_offset : '0;
			end
			r.block_pos = pos_blocks;
			r.entry_pos = pos_entry;
			if (overrun)
				r.status = STATUS_OVERRUN;
			else if (pos_blocks > total_blocks)
				r.status = STATUS_BEYOND;
			else
				r.status = STATUS_OK;
			expected_cursors.push_back(r);
		endfunction

		function int pending();
			return expected_cursors.size();
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] cursor mismatch: %s", $realtime, msg);
			mismatch_count++;
		endtask

		task compare_field(string field, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", field, got, want));
		endtask

		task check_result(logic [M_DATA_W-1:0] data);
			cursor_result_t got;
			cursor_result_t want;
			got = data[171:0];
			if (expected_cursors.size() == 0) begin
				report_mismatch("result transfer with no command outstanding");
				return;
			end
			want = expected_cursors.pop_front();
			compare_field("current_lba", got.lba, want.lba);
			compare_field("buffer_address", got.buffer_addr, want.buffer_addr);
			compare_field("blocks_left_in_entry", 64'(got.blocks_left), 64'(want.blocks_left));
			compare_field("block_position", 64'(got.block_pos), 64'(want.block_pos));
			compare_field("entry_position", 64'(got.entry_pos), 64'(want.entry_pos));
			compare_field("status", 64'(got.status), 64'(want.status));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata;
	logic [1:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_DATA_W-1:0]  m_tdata;

	cursor_tracker cursors = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;

	scatter_gather_block_cursor_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side: check each transfer, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			cursors.check_result(m_tdata);
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic logic [S_DATA_W-1:0] pack_command(logic [IDX_W-1:0] idx,
			logic [ADDR_W-1:0] base, logic [LEN_W-1:0] len, logic [POS_W-1:0] adv);
		return {4'b0, adv, len, base, idx};
	endfunction

	task automatic send_item(input op_t op, input logic [S_DATA_W-1:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		cursors.note_command(op, data);
	endtask

	task automatic send_advance(input logic [POS_W-1:0] adv);
		send_item(OP_ADVANCE, pack_command(IDX_W'($urandom), {$urandom, $urandom}, $urandom, adv));
	endtask

	task automatic write_register(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cursors.set_register(idx, value);
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		while (cursors.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [LBA_W-1:0] lba, input logic [POS_W-1:0] total,
			input logic [ENT_W-1:0] count);
		wait_for_drain();
		write_register(REG_START_LBA, lba);
		write_register(REG_TOTAL_BLOCKS, PDATA_W'(total));
		write_register(REG_ENTRY_COUNT, PDATA_W'(count));
	endtask

	task automatic run_directed();
		logic [ADDR_W-1:0] base;
		logic [LEN_W-1:0]  len;
		// table is not in use yet, so every slot gets loaded first
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			base = {$urandom, $urandom};
			len = (LEN_W'(i % 3 + 1) << BLOCK_LOG2) | LEN_W'($urandom_range(0, 4095));
			case (i)
				0: len = (32'd3 << BLOCK_LOG2) | 32'd100;
				1: begin
					base = '0;
					len = '0;
				end
				2: len = 32'd4095;
				3: len = 32'd2 << BLOCK_LOG2;
				4: begin
					base = '1;
					len = '1;
				end
				default: ;
			endcase
			send_item(OP_LOAD, pack_command(IDX_W'(i), base, len, 16'($urandom)));
		end
		// position only
		send_advance(16'hFFFF);
		send_item(OP_UNUSED, pack_command('1, '1, '1, '1));
		send_item(OP_CLEAR, pack_command('0, '0, '0, '0));

		configure('1, 16'd4, 5'd4);
		send_advance(16'd2);
		send_advance(16'd1);   // lands on a zero-length entry
		send_advance(16'd2);   // skips empty entries, ends exactly at table end
		send_advance(16'd1);   // overrun beats beyond-total
		send_item(OP_CLEAR, pack_command('1, '1, '1, '1));
		send_advance(16'd2);
		// shrink the current entry below the cursor offset
		send_item(OP_LOAD, pack_command(4'd0, {$urandom, $urandom}, 32'd4096, '0));
		send_advance(16'd1);
	endtask

	task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct,
			input bit long_hold);
		op_t               op;
		logic [IDX_W-1:0]  idx;
		logic [ADDR_W-1:0] base;
		logic [LEN_W-1:0]  len;
		logic [POS_W-1:0]  adv;
		int                pick;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			if (long_hold && n == count / 4)
				hold_request = 1'b1;
			idx = IDX_W'($urandom);
			base = {$urandom, $urandom};
			len = $urandom;
			adv = POS_W'($urandom);
			pick = $urandom_range(99);
			if (pick < 25)
				op = OP_LOAD;
			else if (pick < 80)
				op = OP_ADVANCE;
			else if (pick < 92)
				op = OP_CLEAR;
			else
				op = OP_UNUSED;
			// mostly short descriptors and short steps so walks cross entries
			if ($urandom_range(9) != 0)
				len = (LEN_W'($urandom_range(0, 8)) << BLOCK_LOG2) | (len & 32'hFFF);
			pick = $urandom_range(9);
			if (pick < 7)
				adv = POS_W'($urandom_range(0, 12));
			else if (pick < 9)
				adv = POS_W'($urandom_range(0, 300));
			send_item(op, pack_command(idx, base, len, adv));
		end
	endtask

	initial begin
		s_tvalid <= 1'b0;
		s_tuser <= '0;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		m_tready <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		configure({$urandom, $urandom}, 16'hFFFF, 5'd16);
		run_random_phase(225, 0, 0, 1'b1);
		configure('0, 16'd0, 5'd1);
		run_random_phase(225, 68, 0, 1'b0);
		// count above the table size
		configure({$urandom, $urandom}, 16'($urandom_range(0, 200)), 5'd31);
		run_random_phase(225, 0, 68, 1'b0);
		configure('1, 16'($urandom), 5'($urandom_range(0, 16)));
		run_random_phase(225, 11, 11, 1'b0);

		wait_for_drain();
		repeat (80) @(posedge clk);
		if (cursors.mismatch_count == 0 && cursors.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- sim.f -----
src/scgb_pkg.sv
src/scatter_gather_block_cursor_unit.sv
sim/tb.sv
